// File: src/mmw_pkg.sv
`default_nettype none

package mmw_pkg;

    localparam int LIMB_W = 64;
    localparam int CNT_W  = $clog2(LIMB_W);
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LIMB_W - 1);

    localparam logic REG_DIVISOR = 1'b0;

    typedef struct packed {
        logic [LIMB_W-1:0] limb;
        logic              first_limb;
        logic              last_limb;
    } in_t;

    typedef struct packed {
        logic [LIMB_W-1:0] remainder;
        logic              divides_evenly;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_limb;
        logic clear_acc;
        logic load_pre;
        logic step;
        logic out_load;
    } ctl_t;

endpackage

`default_nettype wire

// File: src/mmw_apb.sv
`default_nettype none

module mmw_apb (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mmw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mmw_pkg::DATA_W-1:0] pwdata,
    output logic      [mmw_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output logic      [mmw_pkg::LIMB_W-1:0] divisor,
    output logic                           div_wr
);
    import mmw_pkg::*;

    logic [LIMB_W-1:0] divisor_reg;
    logic [LIMB_W-1:0] divisor_next;
    logic              reg_sel;
    logic              wr_xfer;

    // register index is the 8-byte word number
    assign reg_sel = paddr[ADDR_W-1];
    assign wr_xfer = psel && penable && pwrite && pready;
    assign div_wr  = wr_xfer && (reg_sel == REG_DIVISOR) && (pwdata != '0);

    always_comb
    begin
        divisor_next = divisor_reg;
        if (div_wr)
        begin
            divisor_next = pwdata[LIMB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= LIMB_W'(1);
        end
        else
        begin
            divisor_reg <= divisor_next;
        end
    end

    assign pready  = 1'b1;
    assign divisor = divisor_reg;
    assign prdata  = (reg_sel == REG_DIVISOR) ? DATA_W'(divisor_reg) : '0;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_reg != '0)
        else $error("divisor register holds zero");

    a_zero_write_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_xfer && pwdata == '0) |=> $stable(divisor_reg))
        else $error("zero write changed divisor");

    a_wr_takes: assert property (@(posedge clk) disable iff (!rst_n)
        div_wr |=> (divisor_reg == $past(pwdata[LIMB_W-1:0])))
        else $error("divisor write lost");
`endif

endmodule

`default_nettype wire

// File: src/mmw_dp.sv
`default_nettype none

module mmw_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mmw_pkg::ctl_t             ctl,
    input  wire logic [mmw_pkg::LIMB_W-1:0] limb,
    input  wire logic [mmw_pkg::LIMB_W-1:0] divisor,
    output mmw_pkg::out_t                  out_data
);
    import mmw_pkg::*;

    logic [LIMB_W-1:0] src_reg;
    logic [LIMB_W-1:0] src_next;
    logic [LIMB_W-1:0] acc_reg;
    logic [LIMB_W-1:0] acc_next;
    out_t              out_reg;
    out_t              out_next;
    logic [LIMB_W-1:0] shifted;
    logic              carry;
    logic              take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign carry   = acc_reg[LIMB_W-1];
    assign shifted = {acc_reg[LIMB_W-2:0], src_reg[LIMB_W-1]};
    assign take    = carry || (shifted >= divisor);

    always_comb
    begin
        src_next = src_reg;
        acc_next = acc_reg;
        priority if (ctl.load_pre)
        begin
            // reduce the held remainder under a new divisor
            src_next = acc_reg;
            acc_next = '0;
        end
        else if (ctl.load_limb)
        begin
            src_next = limb;
            if (ctl.clear_acc)
            begin
                acc_next = '0;
            end
        end
        else if (ctl.step)
        begin
            src_next = {src_reg[LIMB_W-2:0], 1'b0};
            acc_next = take ? (shifted - divisor) : shifted;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (ctl.out_load)
        begin
            out_next.remainder      = acc_reg;
            out_next.divides_evenly = (acc_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        out_reg <= out_next;
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_result_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (acc_reg < divisor))
        else $error("remainder not below divisor");

    a_step_keeps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && acc_reg < divisor) |=> (acc_reg < divisor))
        else $error("reduction step left remainder out of range");

    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> (out_reg.divides_evenly == (out_reg.remainder == '0)))
        else $error("divides_evenly disagrees with remainder");
`endif

endmodule

`default_nettype wire

// File: src/mmw_ctrl.sv
`default_nettype none

module mmw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           first_limb,
    input  wire logic           last_limb,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire logic           div_wr,
    output mmw_pkg::ctl_t       ctl
);
    import mmw_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             last_reg;
    logic             last_next;
    logic             rem_ok_reg;
    logic             rem_ok_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_xfer;
    logic             slot_free;
    logic             cnt_done;

    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign cnt_done  = (cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rem_ok_reg ? ST_RUN : ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (cnt_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (cnt_done)
                begin
                    state_next = last_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ctl.load_limb = 1'b0;
        ctl.clear_acc = 1'b0;
        ctl.load_pre  = 1'b0;
        ctl.step      = 1'b0;
        ctl.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = rem_ok_reg;
                ctl.load_limb = in_valid && rem_ok_reg;
                ctl.clear_acc = in_valid && rem_ok_reg && first_limb;
                ctl.load_pre  = in_valid && !rem_ok_reg;
            end
            ST_PRE, ST_RUN:
            begin
                ctl.step = 1'b1;
            end
            ST_DONE:
            begin
                ctl.out_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.load_pre || ctl.load_limb)
        begin
            cnt_next = CNT_MAX;
        end
        else if (ctl.step && !cnt_done)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        last_next = last_reg;
        if (in_xfer)
        begin
            last_next = last_limb;
        end
    end

    // held remainder is below divisor unless the divisor was rewritten
    always_comb
    begin
        rem_ok_next = rem_ok_reg;
        priority if (div_wr)
        begin
            rem_ok_next = 1'b0;
        end
        else if (state_reg == ST_PRE && cnt_done)
        begin
            rem_ok_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            rem_ok_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            rem_ok_reg    <= rem_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_xfer_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RUN && cnt_reg == CNT_MAX))
        else $error("accepted limb did not start reduction");

    a_run_on_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> rem_ok_reg)
        else $error("limb accepted over an unreduced remainder");

    a_pre_sets_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRE && cnt_done && !div_wr) |=> rem_ok_reg)
        else $error("pre-pass did not mark remainder reduced");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result load lost");
`endif

endmodule

`default_nettype wire

// File: src/multiword_mod_by_word_top.sv
// multiword_mod_by_word_top: remainder of a multi-limb unsigned number by a 64-bit word
//
// input channel (in_valid/in_ready/in_data): one 64-bit limb per transfer, most
// significant first; first_limb restarts the number, last_limb asks for a result
// output channel (out_valid/out_ready/out_data): one transfer per last limb with
// the remainder and a divides_evenly flag
// apb port: divisor at address 0, 64-bit data, zero writes are ignored
//
// each limb is shifted bit by bit through the bit-serial restoring reducer, and the
// controller returns to idle before it takes the next limb; a last limb first passes
// through a done state that loads the output register, waiting there while the
// output slot is still full. after a divisor write the held remainder is reduced by
// one extra pass that delays the next limb.
// a finished result sits in an output register; the next limb is accepted
// while it waits, and only the next result waits for out_ready.
// reset: divisor 1, running remainder 0, both channels empty
`default_nettype none

module multiword_mod_by_word_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire mmw_pkg::in_t              in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output mmw_pkg::out_t                  out_data,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mmw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mmw_pkg::DATA_W-1:0] pwdata,
    output logic      [mmw_pkg::DATA_W-1:0] prdata,
    output logic                           pready
);
    import mmw_pkg::*;

    logic [LIMB_W-1:0] divisor;
    logic              div_wr;
    ctl_t              ctl;

    mmw_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .divisor (divisor),
        .div_wr  (div_wr)
    );

    mmw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .limb     (in_data.limb),
        .divisor  (divisor),
        .out_data (out_data)
    );

    mmw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .first_limb (in_data.first_limb),
        .last_limb  (in_data.last_limb),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .div_wr     (div_wr),
        .ctl        (ctl)
    );

endmodule

`default_nettype wire
